>>> src/ihss_pkg.sv
// ----------------------------------------------------------------------------
// ihss_pkg
// Shared types, constants and helpers for the image header size sniffer.
// ----------------------------------------------------------------------------
package ihss_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int WIN_DEPTH      = 24;
  localparam int WIN_IDX_W      = $clog2(WIN_DEPTH);

  typedef logic [POSITION_WIDTH-1:0] pos_t;
  typedef logic [7:0]                byte_t;
  typedef logic [1:0]                fmt_t;
  typedef logic [31:0]               dim_t;

  localparam fmt_t FMT_NONE = 2'd0;
  localparam fmt_t FMT_JPEG = 2'd1;
  localparam fmt_t FMT_GIF  = 2'd2;
  localparam fmt_t FMT_PNG  = 2'd3;

  // JPEG markers
  localparam byte_t MK_FF   = 8'hFF;
  localparam byte_t MK_SOI  = 8'hD8;
  localparam byte_t MK_APP0 = 8'hE0;
  localparam byte_t MK_SOF0 = 8'hC0;
  localparam byte_t MK_SOF1 = 8'hC1;
  localparam byte_t MK_SOF2 = 8'hC2;
  localparam byte_t MK_SOF3 = 8'hC3;
  localparam byte_t MK_SOF9 = 8'hC9;
  localparam byte_t MK_SOFA = 8'hCA;
  localparam byte_t MK_SOFB = 8'hCB;

  // signature bytes
  localparam byte_t SG_PNG  = 8'h89;
  localparam byte_t SG_CR   = 8'h0D;
  localparam byte_t SG_LF   = 8'h0A;
  localparam byte_t SG_EOF  = 8'h1A;
  localparam byte_t CH_J    = 8'h4A;
  localparam byte_t CH_F    = 8'h46;
  localparam byte_t CH_I    = 8'h49;
  localparam byte_t CH_G    = 8'h47;
  localparam byte_t CH_P    = 8'h50;
  localparam byte_t CH_N    = 8'h4E;
  localparam byte_t CH_H    = 8'h48;
  localparam byte_t CH_D    = 8'h44;
  localparam byte_t CH_R    = 8'h52;

  typedef struct packed {
    logic dims_done;
    dim_t width;
    dim_t height;
  } walk_stat_t;

  function automatic logic is_sof(byte_t c);
    return (c == MK_SOF0) || (c == MK_SOF1) || (c == MK_SOF2) || (c == MK_SOF3) ||
           (c == MK_SOF9) || (c == MK_SOFA) || (c == MK_SOFB);
  endfunction

endpackage

>>> src/ihss_if.sv
// ----------------------------------------------------------------------------
// ihss_if
// Valid/ready channels for the byte feed and the result word.
// ----------------------------------------------------------------------------
interface ihss_in_if;
  import ihss_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ihss_out_if;
  import ihss_pkg::*;

  logic valid;
  logic ready;
  logic found;
  fmt_t image_format;
  dim_t image_width;
  dim_t image_height;

  modport source (output valid, found, image_format, image_width, image_height,
                  input ready);
  modport sink   (input valid, found, image_format, image_width, image_height,
                  output ready);
endinterface

>>> src/image_header_size_sniffer_top.sv
// ----------------------------------------------------------------------------
// image_header_size_sniffer_top
// Reads an image file a word at a time and reports format, width and height
// when the last word arrives.
//
//   port    | dir  | payload
//   --------+------+-----------------------------------------------------
//   feed    | in   | data_byte[7:0], last_byte
//   result  | out  | found, image_format[1:0], image_width, image_height
//
// One word per cycle while no result holds a last word back. A last word
// passes the input register, then one stage of compares and counter update
// into the result register. rst is synchronous and clears the file state.
// While a result waits, words of the next file still flow; its last word
// waits in the input register and holds the feed until the result is taken.
// ----------------------------------------------------------------------------
module image_header_size_sniffer_top (
  input logic        clk,
  input logic        rst,
  ihss_in_if.sink    feed,
  ihss_out_if.source result
);
  import ihss_pkg::*;

  logic       s1_valid;
  byte_t      s1_data;
  logic       s1_last;
  logic       s1_fire;
  logic       out_free;

  pos_t       pos;
  byte_t      window [WIN_DEPTH];
  byte_t      w_eff  [WIN_DEPTH];
  logic       pos_ge23;

  walk_stat_t walk_stat;

  logic       jfif, gif, png;
  logic       fnd;
  fmt_t       fmt;
  dim_t       wd, ht;

  logic       out_valid;
  logic       out_found;
  fmt_t       out_fmt;
  dim_t       out_w, out_h;

  assign out_free   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && (!s1_last || out_free);
  assign feed.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= feed.valid;
    end
    if (feed.valid && feed.ready) begin
      s1_data <= feed.data_byte;
      s1_last <= feed.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      pos <= '0;
    end else if (s1_fire && (pos != '1)) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (pos < POSITION_WIDTH'(WIN_DEPTH))) begin
      window[pos[WIN_IDX_W-1:0]] <= s1_data;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w_eff[i] = (pos == POSITION_WIDTH'(i)) ? s1_data : window[i];
    end
  end

  ihss_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .last        (s1_last),
    .pos_nonzero (pos != '0),
    .data        (s1_data),
    .stat        (walk_stat)
  );

  assign pos_ge23 = pos >= POSITION_WIDTH'(23);

  assign jfif = (w_eff[0] == MK_FF) && (w_eff[1] == MK_SOI) && (w_eff[2] == MK_FF) &&
                (w_eff[3] == MK_APP0) && (w_eff[6] == CH_J) && (w_eff[7] == CH_F) &&
                (w_eff[8] == CH_I) && (w_eff[9] == CH_F);
  assign gif  = (w_eff[0] == CH_G) && (w_eff[1] == CH_I) && (w_eff[2] == CH_F);
  assign png  = (w_eff[0] == SG_PNG) && (w_eff[1] == CH_P) && (w_eff[2] == CH_N) &&
                (w_eff[3] == CH_G) && (w_eff[4] == SG_CR) && (w_eff[5] == SG_LF) &&
                (w_eff[6] == SG_EOF) && (w_eff[7] == SG_LF) && (w_eff[12] == CH_I) &&
                (w_eff[13] == CH_H) && (w_eff[14] == CH_D) && (w_eff[15] == CH_R);

  always_comb begin
    fnd = 1'b0;
    fmt = FMT_NONE;
    wd  = '0;
    ht  = '0;
    if (pos_ge23) begin
      priority if (jfif) begin
        if (walk_stat.dims_done) begin
          fnd = 1'b1;
          fmt = FMT_JPEG;
          wd  = walk_stat.width;
          ht  = walk_stat.height;
        end
      end else if (gif) begin
        fnd = 1'b1;
        fmt = FMT_GIF;
        wd  = {16'h0000, w_eff[7], w_eff[6]};
        ht  = {16'h0000, w_eff[9], w_eff[8]};
      end else if (png) begin
        fnd = 1'b1;
        fmt = FMT_PNG;
        wd  = {w_eff[16], w_eff[17], w_eff[18], w_eff[19]};
        ht  = {w_eff[20], w_eff[21], w_eff[22], w_eff[23]};
      end else begin
        fnd = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      out_found <= fnd;
      out_fmt   <= fmt;
      out_w     <= wd;
      out_h     <= ht;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = out_found;
  assign result.image_format = out_fmt;
  assign result.image_width  = out_w;
  assign result.image_height = out_h;

`ifndef SYNTHESIS
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_last))
    else $error("result raised without a last word");

  a_pos_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (pos == '0))
    else $error("byte position not cleared after last word");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |->
      (out_fmt == FMT_NONE) && (out_w == '0) && (out_h == '0))
    else $error("nonzero fields on a not-found result");

  a_stall_no_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready && s1_valid && s1_last) |-> !s1_fire)
    else $error("last word processed while result stalled");
`endif

endmodule

>>> src/ihss_walk.sv
// ----------------------------------------------------------------------------
// ihss_walk
// JPEG marker walker: skips segments by length until a SOF gives the sizes.
// ----------------------------------------------------------------------------
module ihss_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                last,
  input  logic                pos_nonzero,
  input  ihss_pkg::byte_t     data,
  output ihss_pkg::walk_stat_t stat
);
  import ihss_pkg::*;

  localparam logic [2:0] PH_PRE    = 3'd0;
  localparam logic [2:0] PH_FF     = 3'd1;
  localparam logic [2:0] PH_CODE   = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_LEN_LO = 3'd4;
  localparam logic [2:0] PH_SOF    = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;
  localparam logic [2:0] PH_STOP   = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [15:0] seg_left, seg_left_next;
  logic [15:0] held_w, held_w_next;
  logic [15:0] held_h, held_h_next;
  logic        dims_done, dims_done_next;
  logic [15:0] len;
  logic [15:0] seg_dec;

  always_comb begin
    phase_next     = phase;
    seg_left_next  = seg_left;
    held_w_next    = held_w;
    held_h_next    = held_h;
    dims_done_next = dims_done;
    len            = seg_left | {8'h00, data};
    seg_dec        = seg_left - 16'd1;
    unique case (phase)
      PH_PRE: begin
        if (pos_nonzero) phase_next = PH_FF;
      end
      PH_FF: begin
        phase_next = (data == MK_FF) ? PH_CODE : PH_STOP;
      end
      PH_CODE: begin
        seg_left_next = '0;
        phase_next    = is_sof(data) ? PH_SOF : PH_LEN_HI;
      end
      PH_LEN_HI: begin
        seg_left_next = {data, 8'h00};
        phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len < 16'd2) begin
          seg_left_next = '0;
          phase_next    = PH_STOP;
        end else begin
          seg_left_next = len - 16'd2;
          phase_next    = (len == 16'd2) ? PH_FF : PH_SKIP;
        end
      end
      PH_SKIP: begin
        seg_left_next = seg_dec;
        if (seg_dec == '0) phase_next = PH_FF;
      end
      PH_SOF: begin
        unique case (seg_left)
          16'd3: held_h_next = {data, 8'h00};
          16'd4: held_h_next = {held_h[15:8], data};
          16'd5: held_w_next = {data, 8'h00};
          16'd6: held_w_next = {held_w[15:8], data};
          16'd9: begin
            dims_done_next = 1'b1;
            phase_next     = PH_STOP;
          end
          default: ;
        endcase
        seg_left_next = seg_left + 16'd1;
      end
      PH_STOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase     <= PH_PRE;
      seg_left  <= '0;
      held_w    <= '0;
      held_h    <= '0;
      dims_done <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      seg_left  <= seg_left_next;
      held_w    <= held_w_next;
      held_h    <= held_h_next;
      dims_done <= dims_done_next;
    end
  end

  assign stat.dims_done = dims_done_next;
  assign stat.width     = {16'h0000, held_w};
  assign stat.height    = {16'h0000, held_h};

endmodule
